// ===== rtl/c16fd_pkg.sv =====
// Shared types and constants for the CRC-16 frame deframer.
package c16fd_pkg;

    localparam logic [15:0] CRC_START = 16'hFFFF;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_SYNC_FIRST  = 2'd0;
    localparam cfg_index_t CFG_SYNC_SECOND = 2'd1;
    localparam cfg_index_t CFG_MAX_PAYLOAD = 2'd2;
    localparam cfg_index_t CFG_CRC_POLY    = 2'd3;

    typedef enum logic [9:0] {
        PS_SYNC0  = 10'b00_0000_0001,
        PS_SYNC1  = 10'b00_0000_0010,
        PS_TYPE   = 10'b00_0000_0100,
        PS_LEN0   = 10'b00_0000_1000,
        PS_LEN1   = 10'b00_0001_0000,
        PS_LEN2   = 10'b00_0010_0000,
        PS_LEN3   = 10'b00_0100_0000,
        PS_BODY   = 10'b00_1000_0000,
        PS_CRC_HI = 10'b01_0000_0000,
        PS_CRC_LO = 10'b10_0000_0000
    } parse_state_t;

    typedef enum logic [3:0] {
        RP_IDLE  = 4'b0001,
        RP_ISSUE = 4'b0010,
        RP_LOAD  = 4'b0100,
        RP_EMPTY = 4'b1000
    } replay_state_t;

    typedef struct packed {
        logic       start;
        logic       init;
        logic [7:0] data;
    } crc_cmd_t;

endpackage

// ===== rtl/c16fd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module c16fd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/c16fd_crc.sv =====
// Bit-serial CRC-16 unit: folds in one byte at a time, shifting it in bit by bit.
module c16fd_crc (
    input  logic                clk,
    input  logic                rst_n,
    input  c16fd_pkg::crc_cmd_t cmd,
    input  logic [15:0]         poly,
    output logic                busy,
    output logic [15:0]         crc
);
    import c16fd_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] base;

    always_comb
    begin
        base     = cmd.init ? CRC_START : crc_reg;
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        if (cmd.start)
        begin
            crc_next = base ^ {cmd.data, 8'h00};
            cnt_next = 4'd8;
        end
        else if (cnt_reg != 4'd0)
        begin
            crc_next = crc_reg[15] ? ({crc_reg[14:0], 1'b0} ^ poly)
                                   : {crc_reg[14:0], 1'b0};
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_START;
            cnt_reg <= 4'd0;
        end
        else
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign busy = (cnt_reg != 4'd0);
    assign crc  = crc_reg;

endmodule

// ===== rtl/crc16_frame_deframer.sv =====
// Top level of the sync/length/CRC-16 frame deframer.
//
// Input channel (in_valid/in_ready, rx_byte) takes one received byte per
// transaction. Sync bytes, a repeat of the first sync byte and the low CRC
// byte are taken back to back; the high CRC byte waits for the CRC unit.
// Type, length and payload bytes pass through the bit-serial CRC unit, so
// the next byte is held off until the CRC unit has shifted that byte in.
// When the low CRC byte matches, the frame is replayed on the output channel
// (out_valid/out_ready) as one transaction per payload byte, or a single
// transaction with has_byte low for an empty frame. Each replayed result
// takes a store read and an output load; input is held off during replay.
// Results sit in an output register: a stalled receiver holds the replay,
// and the last result may wait there while the next frame is received.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data).
// Reset returns the parser to the sync hunt and the registers to defaults;
// the payload store is not cleared.
module crc16_frame_deframer #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  c16fd_pkg::cfg_index_t  cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             frame_type,
    output logic [6:0]             frame_length,
    output logic                   has_byte,
    output logic [5:0]             byte_index,
    output logic [7:0]             payload_data,
    output logic                   last
);
    import c16fd_pkg::*;

    localparam int          ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [6:0]  DEPTH_W = 7'(STORE_DEPTH);

    logic [7:0]  sync_first_reg, sync_second_reg;
    logic [6:0]  max_payload_reg;
    logic [15:0] crc_poly_reg;

    parse_state_t  ps_reg, ps_next;
    replay_state_t rp_reg, rp_next;

    logic [7:0]  type_reg, type_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic        len_hnz_reg, len_hnz_next;
    logic [6:0]  len_reg, len_next;
    logic [6:0]  fill_reg, fill_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic [6:0]  k_reg, k_next;

    logic        ov_reg, ov_next;
    logic [7:0]  o_type_reg, o_type_next;
    logic [6:0]  o_len_reg, o_len_next;
    logic        o_has_reg, o_has_next;
    logic [5:0]  o_idx_reg, o_idx_next;
    logic [7:0]  o_data_reg, o_data_next;
    logic        o_last_reg, o_last_next;

    crc_cmd_t    crc_cmd;
    logic        crc_busy;
    logic [15:0] crc_val;

    logic        accept;
    logic        out_free;
    logic [6:0]  limit;
    logic        ram_we, ram_re;
    logic [7:0]  ram_rdata;

    c16fd_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (crc_cmd),
        .poly  (crc_poly_reg),
        .busy  (crc_busy),
        .crc   (crc_val)
    );

    c16fd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (k_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= 8'hAB;
            sync_second_reg <= 8'hCD;
            max_payload_reg <= 7'd64;
            crc_poly_reg    <= 16'h1021;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data[7:0];
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data[7:0];
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data[6:0];
                CFG_CRC_POLY:    crc_poly_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign limit    = (max_payload_reg > DEPTH_W) ? DEPTH_W : max_payload_reg;
    assign in_ready = (rp_reg == RP_IDLE) && !crc_busy;
    assign accept   = in_valid && in_ready;
    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        ps_next      = ps_reg;
        rp_next      = rp_reg;
        type_next    = type_reg;
        len_lo_next  = len_lo_reg;
        len_hnz_next = len_hnz_reg;
        len_next     = len_reg;
        fill_next    = fill_reg;
        crc_hi_next  = crc_hi_reg;
        k_next       = k_reg;
        crc_cmd      = '{start: 1'b0, init: 1'b0, data: rx_byte};
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        ov_next      = ov_reg && !out_ready;
        o_type_next  = o_type_reg;
        o_len_next   = o_len_reg;
        o_has_next   = o_has_reg;
        o_idx_next   = o_idx_reg;
        o_data_next  = o_data_reg;
        o_last_next  = o_last_reg;

        if (accept)
        begin
            case (ps_reg)
                PS_SYNC0:
                begin
                    if (rx_byte == sync_first_reg)
                    begin
                        ps_next = PS_SYNC1;
                    end
                end
                PS_SYNC1:
                begin
                    if (rx_byte == sync_second_reg)
                    begin
                        ps_next = PS_TYPE;
                    end
                    else if (rx_byte != sync_first_reg)
                    begin
                        ps_next = PS_SYNC0;
                    end
                end
                PS_TYPE:
                begin
                    type_next     = rx_byte;
                    crc_cmd.start = 1'b1;
                    crc_cmd.init  = 1'b1;
                    ps_next       = PS_LEN0;
                end
                PS_LEN0:
                begin
                    len_lo_next   = rx_byte;
                    len_hnz_next  = 1'b0;
                    crc_cmd.start = 1'b1;
                    ps_next       = PS_LEN1;
                end
                PS_LEN1:
                begin
                    len_hnz_next  = len_hnz_reg | (|rx_byte);
                    crc_cmd.start = 1'b1;
                    ps_next       = PS_LEN2;
                end
                PS_LEN2:
                begin
                    len_hnz_next  = len_hnz_reg | (|rx_byte);
                    crc_cmd.start = 1'b1;
                    ps_next       = PS_LEN3;
                end
                PS_LEN3:
                begin
                    crc_cmd.start = 1'b1;
                    len_next      = len_lo_reg[6:0];
                    if (!len_hnz_reg && (rx_byte == 8'd0) && (len_lo_reg == 8'd0))
                    begin
                        ps_next = PS_CRC_HI;
                    end
                    else if (len_hnz_reg || (|rx_byte) || (len_lo_reg > {1'b0, limit}))
                    begin
                        ps_next = PS_SYNC0;
                    end
                    else
                    begin
                        fill_next = 7'd0;
                        ps_next   = PS_BODY;
                    end
                end
                PS_BODY:
                begin
                    ram_we        = (fill_reg < DEPTH_W);
                    fill_next     = fill_reg + 7'd1;
                    crc_cmd.start = 1'b1;
                    if ((fill_reg + 7'd1) >= len_reg)
                    begin
                        ps_next = PS_CRC_HI;
                    end
                end
                PS_CRC_HI:
                begin
                    crc_hi_next = rx_byte;
                    ps_next     = PS_CRC_LO;
                end
                PS_CRC_LO:
                begin
                    ps_next = PS_SYNC0;
                    if ({crc_hi_reg, rx_byte} == crc_val)
                    begin
                        k_next  = 7'd0;
                        rp_next = (len_reg == 7'd0) ? RP_EMPTY : RP_ISSUE;
                    end
                end
                default:
                begin
                    ps_next = PS_SYNC0;
                end
            endcase
        end

        case (rp_reg)
            RP_IDLE: ;
            RP_ISSUE:
            begin
                ram_re  = 1'b1;
                rp_next = RP_LOAD;
            end
            RP_LOAD:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_type_next = type_reg;
                    o_len_next  = len_reg;
                    o_has_next  = 1'b1;
                    o_idx_next  = k_reg[5:0];
                    o_data_next = ram_rdata;
                    o_last_next = ((k_reg + 7'd1) == len_reg);
                    k_next      = k_reg + 7'd1;
                    rp_next     = ((k_reg + 7'd1) == len_reg) ? RP_IDLE : RP_ISSUE;
                end
            end
            RP_EMPTY:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_type_next = type_reg;
                    o_len_next  = 7'd0;
                    o_has_next  = 1'b0;
                    o_idx_next  = 6'd0;
                    o_data_next = 8'd0;
                    o_last_next = 1'b1;
                    rp_next     = RP_IDLE;
                end
            end
            default:
            begin
                rp_next = RP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg      <= PS_SYNC0;
            rp_reg      <= RP_IDLE;
            ov_reg      <= 1'b0;
            type_reg    <= 8'd0;
            len_lo_reg  <= 8'd0;
            len_hnz_reg <= 1'b0;
            len_reg     <= 7'd0;
            fill_reg    <= 7'd0;
            crc_hi_reg  <= 8'd0;
            k_reg       <= 7'd0;
        end
        else
        begin
            ps_reg      <= ps_next;
            rp_reg      <= rp_next;
            ov_reg      <= ov_next;
            type_reg    <= type_next;
            len_lo_reg  <= len_lo_next;
            len_hnz_reg <= len_hnz_next;
            len_reg     <= len_next;
            fill_reg    <= fill_next;
            crc_hi_reg  <= crc_hi_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_type_reg <= o_type_next;
        o_len_reg  <= o_len_next;
        o_has_reg  <= o_has_next;
        o_idx_reg  <= o_idx_next;
        o_data_reg <= o_data_next;
        o_last_reg <= o_last_next;
    end

    assign out_valid    = ov_reg;
    assign frame_type   = o_type_reg;
    assign frame_length = o_len_reg;
    assign has_byte     = o_has_reg;
    assign byte_index   = o_idx_reg;
    assign payload_data = o_data_reg;
    assign last         = o_last_reg;

endmodule
